@@ hw/rtl/abae_pkg.sv @@
// Shared constants, opcodes and controller/datapath interface types.
`default_nettype none
package abae_pkg;
    localparam int RANGE_BITS   = 16;
    localparam int NUM_CONTEXTS = 64;
    localparam int COUNT_BITS   = 16;

    localparam int BW      = RANGE_BITS + 1;               // interval bound width
    localparam int CTX_W   = 6;                            // context_index field width
    localparam int CTX_AW  = $clog2(NUM_CONTEXTS);         // context memory address width
    localparam int CFG_W   = 16;                           // config register width
    localparam int RUN_W   = 16;                           // follow_run width
    localparam int DIV_NW  = COUNT_BITS + RANGE_BITS + 2;  // divider numerator width
    localparam int DIV_DW  = COUNT_BITS + 1;               // divider denominator width
    localparam int K_W     = $clog2(RANGE_BITS + 2);       // renorm step counter width

    localparam logic [1:0] OP_ENCODE = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [CFG_W-1:0] RST_INITIAL_TOTAL = 16'd64;
    localparam logic [CFG_W-1:0] RST_RESCALE_TOTAL = 16'd32;

    typedef struct packed {
        logic item_ld;      // latch accepted input beat
        logic rd_ctx;       // read context memory at item context
        logic rd_idx;       // read context memory at sweep index
        logic div_enc;      // start split-point division
        logic div_resc;     // start rescale division
        logic mul;          // register diff * p
        logic bnd;          // update bounds, write context counts
        logic ren_step;     // one renormalization step
        logic fin_ld;       // load flush working values
        logic fin_step;     // one flush digit
        logic push_final;   // push held result with last
        logic sw_clr;       // clear sweep index
        logic sw_wr_load;   // write loaded counts at sweep index
        logic sw_wr_resc;   // write rescaled counts at sweep index
        logic intv_rst;     // reset interval and pending count
    } abae_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       div_done;
        logic       ren_act;
        logic       ren_emit;
        logic       fin_act;
        logic       hold_busy;
        logic       out_free;
        logic       sw_last;
    } abae_stat_t;
endpackage
`default_nettype wire

@@ hw/rtl/adaptive_binary_arith_encoder.sv @@
// Top level: stream ports, APB config registers, controller and datapath.
//
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+-----------------------------------------
// s_       | in        | s_tvalid/s_tready  | tuser opcode, tdata symbol/context
// m_       | out       | m_tvalid/m_tready  | tuser has_bit, tdata lead/run, tlast
// apb      | in        | psel/penable/pready| initial_total @0x0, rescale_total @0x4
//
// Sequencing: one input beat at a time. Encode waits on the serial divider (one quotient
// bit per cycle), then does up to 17 renormalization steps. Finish takes up to 16 flush
// steps plus a rescale sweep over all 64 contexts. The reset opcode writes each of the
// 64 contexts in turn. Result beats may stall when m_tready is low; one result is held
// internally and one sits in the output register. Reset is synchronous, active low, and
// needs no clearing pass.
`default_nettype none
module adaptive_binary_arith_encoder (
    input  wire         aclk,
    input  wire         aresetn,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [0] symbol_bit, [6:1] context_index, [7] zero
    input  wire  [1:0]  s_tuser,   // [1:0] opcode
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // [0] lead_bit, [16:1] follow_run, [23:17] zero
    output logic        m_tuser,   // [0] has_bit
    output logic        m_tlast,
    // config port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CW = abae_pkg::CFG_W;

    logic [CW-1:0] init_total_reg, resc_total_reg;
    abae_pkg::abae_cmd_t  cmd;
    abae_pkg::abae_stat_t stat;
    logic                         out_lead;
    logic [abae_pkg::RUN_W-1:0]   out_run;

    // config registers: bit 2 of the address selects the register
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_total_reg <= abae_pkg::RST_INITIAL_TOTAL;
            resc_total_reg <= abae_pkg::RST_RESCALE_TOTAL;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) resc_total_reg <= pwdata[CW-1:0];
            else          init_total_reg <= pwdata[CW-1:0];
        end
    end
    assign prdata = paddr[2] ? {{(32-CW){1'b0}}, resc_total_reg}
                             : {{(32-CW){1'b0}}, init_total_reg};

    abae_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    abae_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .in_op         (s_tuser),
        .in_bit        (s_tdata[0]),
        .in_ctx        (s_tdata[6:1]),
        .initial_total (init_total_reg),
        .rescale_total (resc_total_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_has       (m_tuser),
        .out_lead      (out_lead),
        .out_run       (out_run),
        .out_last      (m_tlast)
    );

    assign m_tdata = {7'd0, out_run, out_lead};
endmodule
`default_nettype wire

@@ hw/rtl/abae_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none
module abae_div (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire [abae_pkg::DIV_NW-1:0]   num,
    input  wire [abae_pkg::DIV_DW-1:0]   den,
    output logic [abae_pkg::DIV_NW-1:0]  quo,
    output logic                         done
);
    localparam int NW  = abae_pkg::DIV_NW;
    localparam int DW  = abae_pkg::DIV_DW;
    localparam int CW  = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] q_reg;
    logic [DW-1:0] rem_reg, den_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic          qbit;

    always_comb begin
        trial = {rem_reg, q_reg[NW-1]};
        qbit  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CW'(NW);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) done_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (cnt_reg != '0) begin
            q_reg   <= {q_reg[NW-2:0], qbit};
            rem_reg <= qbit ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
        end
    end

    assign quo  = q_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

@@ hw/rtl/abae_datapath.sv @@
// Coder datapath: interval, context memory, divider, result hold and output register.
`default_nettype none
module abae_datapath (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  abae_pkg::abae_cmd_t             cmd,
    output abae_pkg::abae_stat_t            stat,
    input  wire [1:0]                       in_op,
    input  wire                             in_bit,
    input  wire [abae_pkg::CTX_W-1:0]       in_ctx,
    input  wire [abae_pkg::CFG_W-1:0]       initial_total,
    input  wire [abae_pkg::CFG_W-1:0]       rescale_total,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic                            out_has,
    output logic                            out_lead,
    output logic [abae_pkg::RUN_W-1:0]      out_run,
    output logic                            out_last
);
    localparam int R   = abae_pkg::RANGE_BITS;
    localparam int BW  = abae_pkg::BW;
    localparam int CB  = abae_pkg::COUNT_BITS;
    localparam int AW  = abae_pkg::CTX_AW;
    localparam int NC  = abae_pkg::NUM_CONTEXTS;
    localparam int NW  = abae_pkg::DIV_NW;
    localparam int DW  = abae_pkg::DIV_DW;
    localparam int RW  = abae_pkg::RUN_W;
    localparam int KW  = abae_pkg::K_W;
    localparam logic [BW-1:0] RMAX  = BW'(1) << R;
    localparam logic [BW-1:0] HALF  = BW'(1) << (R - 1);
    localparam logic [BW-1:0] QTR1  = BW'(1) << (R - 2);
    localparam logic [BW-1:0] QTR3  = HALF + QTR1;
    localparam logic [CB-1:0] CMAX  = '1;
    localparam logic [RW-1:0] RUNMAX = '1;

    // item and interval state
    logic [1:0]          op_reg;
    logic                bit_reg;
    logic [AW-1:0]       ctx_reg;
    logic [BW-1:0]       lo_reg, hi_reg;
    logic [RW-1:0]       pend_reg;
    logic [KW-1:0]       k_reg;
    logic [CB-1:0]       z_reg, t_reg;
    logic [2*BW-1:0]     prod_reg;
    logic signed [BW:0]  flo_reg, fhi_reg;
    logic [BW-1:0]       val_reg;
    logic                fdone_reg;
    logic [AW-1:0]       idx_reg;

    // context memory
    logic [2*CB-1:0]     mem [NC];
    logic [NC-1:0]       vld_reg;
    logic [2*CB-1:0]     rd_q_reg;
    logic                rd_v_reg;

    // result hold and output
    logic                hold_v_reg, hold_b_reg;
    logic [RW-1:0]       hold_r_reg;
    logic                m_v_reg, m_h_reg, m_b_reg, m_l_reg;
    logic [RW-1:0]       m_r_reg;

    logic [AW-1:0]       ctx_clamp, rd_addr, wr_addr;
    logic                wr_en;
    logic [2*CB-1:0]     wr_data;
    logic [CB-1:0]       z_mem, t_mem, t_eff;
    logic                div_start, div_done;
    logic [NW-1:0]       div_num, div_q;
    logic [DW-1:0]       div_den;
    logic [BW-1:0]       p_clamp, diff, add_raw, add_c;
    logic                c1, c2, c3, out_free;
    logic                emit_en, emit_b;
    logic [RW-1:0]       emit_r;
    logic [NW-1:0]       rq_c;
    logic [CB-1:0]       z_upd, t_upd;

    always_comb begin
        if ({1'b0, in_ctx} >= (abae_pkg::CTX_W + 1)'(NC)) ctx_clamp = AW'(NC - 1);
        else                                               ctx_clamp = AW'(in_ctx);
    end

    // memory read, registered
    assign rd_addr = cmd.rd_idx ? idx_reg : ctx_reg;
    always_ff @(posedge aclk) begin
        if (cmd.rd_ctx || cmd.rd_idx) begin
            rd_q_reg <= mem[rd_addr];
            rd_v_reg <= vld_reg[rd_addr];
        end
        if (wr_en) mem[wr_addr] <= wr_data;
    end

    always_comb begin
        z_mem = rd_v_reg ? rd_q_reg[CB-1:0]    : CB'(abae_pkg::RST_INITIAL_TOTAL >> 1);
        t_mem = rd_v_reg ? rd_q_reg[2*CB-1:CB] : CB'(abae_pkg::RST_INITIAL_TOTAL);
        t_eff = (t_mem == '0) ? CB'(1) : t_mem;
    end

    // divider operands
    assign div_start = cmd.div_enc | cmd.div_resc;
    always_comb begin
        if (cmd.div_resc) begin
            div_num = NW'(z_mem * rescale_total);
            div_den = DW'(t_eff);
        end else begin
            div_num = (NW'(z_mem) << (R + 1)) + NW'(t_eff);
            div_den = {t_eff, 1'b0};
        end
    end

    abae_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_q),
        .done    (div_done)
    );

    always_comb begin
        p_clamp = (div_q > NW'(RMAX)) ? RMAX : div_q[BW-1:0];
        diff    = hi_reg - lo_reg;
        add_raw = BW'(prod_reg >> R);
        if (add_raw == '0)       add_c = BW'(1);
        else if (add_raw == diff) add_c = diff - 1'b1;
        else                     add_c = add_raw;
        z_upd = (!bit_reg && z_reg != CMAX) ? z_reg + 1'b1 : z_reg;
        t_upd = (t_reg != CMAX) ? t_reg + 1'b1 : t_reg;
        rq_c  = (div_q == '0) ? NW'(1) : div_q;
        if (rq_c >= NW'(rescale_total))
            rq_c = (rescale_total != '0) ? NW'(rescale_total - 1'b1) : '0;
    end

    // renormalization conditions
    always_comb begin
        c1 = (hi_reg <= HALF);
        c2 = (lo_reg >= HALF);
        c3 = (lo_reg >= QTR1) && (hi_reg <= QTR3);
    end

    // memory write port
    always_comb begin
        wr_en   = cmd.bnd | cmd.sw_wr_load | cmd.sw_wr_resc;
        wr_addr = cmd.bnd ? ctx_reg : idx_reg;
        if (cmd.bnd)
            wr_data = {t_upd, z_upd};
        else if (cmd.sw_wr_load)
            wr_data = {CB'(initial_total), CB'(initial_total >> 1)};
        else
            wr_data = {CB'(rescale_total),
                       (rq_c > NW'(CMAX)) ? CMAX : rq_c[CB-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (wr_en) vld_reg[wr_addr] <= 1'b1;
    end

    // result emission
    always_comb begin
        emit_en = 1'b0;
        emit_b  = 1'b0;
        emit_r  = '0;
        if (cmd.ren_step && (c1 || c2)) begin
            emit_en = 1'b1;
            emit_b  = !c1;
            emit_r  = pend_reg;
        end else if (cmd.fin_step) begin
            emit_en = 1'b1;
            emit_b  = (pend_reg != '0) || ($signed({1'b0, val_reg}) < fhi_reg);
        end
    end

    assign out_free = !m_v_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_v_reg <= 1'b0;
            m_v_reg    <= 1'b0;
        end else begin
            if (emit_en) begin
                hold_v_reg <= 1'b1;
                hold_b_reg <= emit_b;
                hold_r_reg <= emit_r;
            end else if (cmd.push_final) begin
                hold_v_reg <= 1'b0;
            end
            if ((emit_en && hold_v_reg) || cmd.push_final) begin
                m_v_reg <= 1'b1;
                m_h_reg <= hold_v_reg;
                m_b_reg <= hold_v_reg & hold_b_reg;
                m_r_reg <= hold_v_reg ? hold_r_reg : '0;
                m_l_reg <= cmd.push_final;
            end else if (out_ready) begin
                m_v_reg <= 1'b0;
            end
        end
    end

    // interval and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg   <= '0;
            hi_reg   <= RMAX;
            pend_reg <= '0;
        end else begin
            if (cmd.bnd) begin
                if (!bit_reg) hi_reg <= lo_reg + add_c;
                else          lo_reg <= lo_reg + add_c;
            end
            if (cmd.ren_step) begin
                if (c1) begin
                    pend_reg <= '0;
                    lo_reg   <= lo_reg << 1;
                    hi_reg   <= hi_reg << 1;
                end else if (c2) begin
                    pend_reg <= '0;
                    lo_reg   <= (lo_reg - HALF) << 1;
                    hi_reg   <= (hi_reg - HALF) << 1;
                end else begin
                    if (pend_reg != RUNMAX) pend_reg <= pend_reg + 1'b1;
                    lo_reg   <= (lo_reg - QTR1) << 1;
                    hi_reg   <= (hi_reg - QTR1) << 1;
                end
            end
            if (cmd.intv_rst) begin
                lo_reg   <= '0;
                hi_reg   <= RMAX;
                pend_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_ld) begin
            op_reg  <= in_op;
            bit_reg <= in_bit;
            ctx_reg <= ctx_clamp;
        end
        if (cmd.div_enc) begin
            z_reg <= z_mem;
            t_reg <= t_mem;
        end
        if (cmd.mul) prod_reg <= diff * p_clamp;
        if (cmd.bnd) k_reg <= '0;
        else if (cmd.ren_step) k_reg <= k_reg + 1'b1;
        if (cmd.fin_ld) begin
            flo_reg   <= $signed({1'b0, lo_reg});
            fhi_reg   <= $signed({1'b0, hi_reg});
            val_reg   <= HALF;
            fdone_reg <= 1'b0;
        end else if (cmd.fin_step) begin
            if (pend_reg != '0) begin
                fdone_reg <= 1'b1;
            end else begin
                if ($signed({1'b0, val_reg}) < fhi_reg) begin
                    flo_reg <= flo_reg - $signed({1'b0, val_reg});
                    fhi_reg <= fhi_reg - $signed({1'b0, val_reg});
                end
                val_reg <= val_reg >> 1;
            end
        end
        if (cmd.sw_clr) idx_reg <= '0;
        else if (cmd.sw_wr_load || cmd.sw_wr_resc) idx_reg <= idx_reg + 1'b1;
    end

    always_comb begin
        stat.op        = op_reg;
        stat.div_done  = div_done;
        stat.ren_act   = (k_reg <= KW'(R)) && (c1 || c2 || c3);
        stat.ren_emit  = c1 || c2;
        stat.fin_act   = (pend_reg != '0) ? !fdone_reg
                                          : ((flo_reg > 0) && (val_reg != '0));
        stat.hold_busy = hold_v_reg && !out_free;
        stat.out_free  = out_free;
        stat.sw_last   = (idx_reg == AW'(NC - 1));
    end

    assign out_valid = m_v_reg;
    assign out_has   = m_h_reg;
    assign out_lead  = m_b_reg;
    assign out_run   = m_r_reg;
    assign out_last  = m_l_reg;
endmodule
`default_nettype wire

@@ hw/rtl/abae_ctrl.sv @@
// Sequencer for encode, flush, rescale sweep and counter load.
`default_nettype none
module abae_ctrl (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    in_valid,
    input  wire [1:0]              in_op,
    output logic                   in_ready,
    input  abae_pkg::abae_stat_t   stat,
    output abae_pkg::abae_cmd_t    cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD     = 4'd1;
    localparam logic [3:0] S_DIV    = 4'd2;
    localparam logic [3:0] S_DWAIT  = 4'd3;
    localparam logic [3:0] S_MUL    = 4'd4;
    localparam logic [3:0] S_BND    = 4'd5;
    localparam logic [3:0] S_REN    = 4'd6;
    localparam logic [3:0] S_FSTEP  = 4'd7;
    localparam logic [3:0] S_FINAL  = 4'd8;
    localparam logic [3:0] S_LOAD   = 4'd9;
    localparam logic [3:0] S_SWRD   = 4'd10;
    localparam logic [3:0] S_SWDIV  = 4'd11;
    localparam logic [3:0] S_SWWAIT = 4'd12;
    localparam logic [3:0] S_SWWR   = 4'd13;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.item_ld = 1'b1;
                    case (in_op)
                        abae_pkg::OP_ENCODE: state_next = S_RD;
                        abae_pkg::OP_FINISH: begin
                            cmd.fin_ld = 1'b1;
                            state_next = S_FSTEP;
                        end
                        abae_pkg::OP_RESET: begin
                            cmd.sw_clr = 1'b1;
                            state_next = S_LOAD;
                        end
                        default: state_next = S_FINAL;
                    endcase
                end
            end
            S_RD: begin
                cmd.rd_ctx = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_enc = 1'b1;
                state_next  = S_DWAIT;
            end
            S_DWAIT: if (stat.div_done) state_next = S_MUL;
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_BND;
            end
            S_BND: begin
                cmd.bnd    = 1'b1;
                state_next = S_REN;
            end
            S_REN: begin
                if (!stat.ren_act) state_next = S_FINAL;
                else if (!(stat.ren_emit && stat.hold_busy)) cmd.ren_step = 1'b1;
            end
            S_FSTEP: begin
                if (!stat.fin_act) state_next = S_FINAL;
                else if (!stat.hold_busy) cmd.fin_step = 1'b1;
            end
            S_FINAL: begin
                if (stat.out_free) begin
                    cmd.push_final = 1'b1;
                    if (stat.op == abae_pkg::OP_FINISH) begin
                        cmd.sw_clr = 1'b1;
                        state_next = S_SWRD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_LOAD: begin
                cmd.sw_wr_load = 1'b1;
                if (stat.sw_last) state_next = S_FINAL;
            end
            S_SWRD: begin
                cmd.rd_idx = 1'b1;
                state_next = S_SWDIV;
            end
            S_SWDIV: begin
                cmd.div_resc = 1'b1;
                state_next   = S_SWWAIT;
            end
            S_SWWAIT: if (stat.div_done) state_next = S_SWWR;
            S_SWWR: begin
                cmd.sw_wr_resc = 1'b1;
                if (stat.sw_last) begin
                    cmd.intv_rst = 1'b1;
                    state_next   = S_IDLE;
                end else begin
                    state_next = S_SWRD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the adaptive binary arithmetic encoder.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    localparam logic [2:0] ADDR_INIT_TOTAL    = 3'd0;
    localparam logic [2:0] ADDR_RESCALE_TOTAL = 3'd4;
    localparam int         N_RANDOM           = 200;
    localparam int         DRAIN_CYCLES       = 3000;

    typedef struct packed {
        logic        has_bit;
        logic        lead_bit;
        logic [15:0] follow_run;
        logic        last;
    } code_beat_t;

    // Scoreboard: keeps its own copy of the coder state and the expected beats.
    class code_scoreboard;
        code_beat_t  pending_beats[$];
        int          errors;
        logic [16:0] lo_b, hi_b;
        logic [15:0] follow_cnt;
        logic [15:0] zeros[abae_pkg::NUM_CONTEXTS];
        logic [15:0] totals[abae_pkg::NUM_CONTEXTS];
        logic [15:0] init_total, resc_total;

        function void power_on();
            init_total = abae_pkg::RST_INITIAL_TOTAL;
            resc_total = abae_pkg::RST_RESCALE_TOTAL;
            errors     = 0;
            clear_interval();
            load_counts();
        endfunction

        function void clear_interval();
            lo_b       = '0;
            hi_b       = 17'h10000;
            follow_cnt = '0;
        endfunction

        function void load_counts();
            for (int i = 0; i < abae_pkg::NUM_CONTEXTS; i++) begin
                zeros[i]  = init_total >> 1;
                totals[i] = init_total;
            end
        endfunction

        function void push_beat(logic hb, logic lb, logic [15:0] run);
            code_beat_t b;
            b.has_bit    = hb;
            b.lead_bit   = lb;
            b.follow_run = run;
            b.last       = 1'b0;
            pending_beats = {pending_beats, b};
        endfunction

        function void code_symbol(logic sym, int ctx);
            longint unsigned z, t, p, diff, add, lo, hi;
            z    = zeros[ctx];
            t    = (totals[ctx] == 0) ? 1 : totals[ctx];
            p    = ((z << 17) + t) / (t << 1);
            lo   = lo_b;
            hi   = hi_b;
            diff = hi - lo;
            if (p > 65536) p = 65536;
            add = (diff * p) >> 16;
            if (add == 0) add = 1;
            else if (add == diff) add = diff - 1;
            if (sym == 1'b0) hi = lo + add;
            else lo = lo + add;
            for (int k = 0; k <= 16; k++) begin
                if (hi <= 32768) begin
                    push_beat(1'b1, 1'b0, follow_cnt);
                    follow_cnt = 0;
                end else if (lo >= 32768) begin
                    push_beat(1'b1, 1'b1, follow_cnt);
                    follow_cnt = 0;
                    lo -= 32768;
                    hi -= 32768;
                end else if (lo >= 16384 && hi <= 49152) begin
                    if (follow_cnt != 16'hFFFF) follow_cnt++;
                    lo -= 16384;
                    hi -= 16384;
                end else begin
                    break;
                end
                lo = (lo << 1) & 64'h1FFFF;
                hi = (hi << 1) & 64'h1FFFF;
            end
            lo_b = lo[16:0];
            hi_b = hi[16:0];
            if (sym == 1'b0 && zeros[ctx] != 16'hFFFF) zeros[ctx]++;
            if (totals[ctx] != 16'hFFFF) totals[ctx]++;
        endfunction

        function void flush_code();
            longint lo, hi, v;
            longint unsigned t, q;
            if (follow_cnt > 0) begin
                push_beat(1'b1, 1'b1, 16'd0);
            end else begin
                lo = lo_b;
                hi = hi_b;
                v  = 32768;
                while (lo > 0 && v > 0) begin
                    if (v < hi) begin
                        push_beat(1'b1, 1'b1, 16'd0);
                        lo -= v;
                        hi -= v;
                    end else begin
                        push_beat(1'b1, 1'b0, 16'd0);
                    end
                    v >>= 1;
                end
            end
            for (int i = 0; i < abae_pkg::NUM_CONTEXTS; i++) begin
                t = (totals[i] == 0) ? 1 : totals[i];
                q = (longint'(zeros[i]) * resc_total) / t;
                if (q == 0) q = 1;
                if (q >= resc_total) q = (resc_total != 0) ? resc_total - 1 : 0;
                zeros[i]  = q[15:0];
                totals[i] = resc_total;
            end
            clear_interval();
        endfunction

        // Note an accepted input beat and queue every beat it causes.
        function void note_input(logic [1:0] op, logic sym, logic [5:0] ctx);
            int before_n;
            before_n = pending_beats.size();
            case (op)
                abae_pkg::OP_ENCODE: code_symbol(sym, ctx);
                abae_pkg::OP_FINISH: flush_code();
                abae_pkg::OP_RESET:  load_counts();
                default: ;
            endcase
            if (pending_beats.size() == before_n) push_beat(1'b0, 1'b0, 16'd0);
            pending_beats[pending_beats.size()-1].last = 1'b1;
        endfunction

        task check_beat(code_beat_t got);
            code_beat_t want;
            if (pending_beats.size() == 0) begin
                report("unexpected result beat");
                return;
            end
            want = pending_beats.pop_front();
            if (got.has_bit !== want.has_bit) report("has_bit mismatch");
            if (got.lead_bit !== want.lead_bit) report("lead_bit mismatch");
            if (got.follow_run !== want.follow_run) report("follow_run mismatch");
            if (got.last !== want.last) report("last mismatch");
        endtask

        task report(string what);
            $display("ERROR %0t: %s", $realtime, what);
            errors++;
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [0] symbol_bit, [6:1] context_index, [7] zero
    logic [1:0]  s_tuser;   // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [0] lead_bit, [16:1] follow_run, [23:17] zero
    logic        m_tuser;   // [0] has_bit
    logic        m_tlast;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    code_scoreboard sb;
    int          stall_mode;   // receiver stall pattern selector

    adaptive_binary_arith_encoder uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        aclk = 1'b0; #5;
        aclk = 1'b1; #5;
    end

    // Receiver: accept and check on each completed beat, then pick next tready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_beat({m_tuser, m_tdata[0], m_tdata[16:1], m_tlast});
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ($urandom_range(0, 1) == 0);
        endcase
    end

    // Input beats are noted in the scoreboard at the edge of acceptance.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_input(s_tuser, s_tdata[0], s_tdata[6:1]);
    end

    task automatic send_item(logic [1:0] op, logic sym, logic [5:0] ctx);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, ctx, sym};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_sender(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Wait until all expected beats arrived, then let the block settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_INIT_TOTAL) sb.init_total = val;
        else sb.resc_total = val;
        @(posedge aclk);
    endtask

    // Random phase: bursts of mostly encode items mixed with finish, reset and unused opcodes, with idle gaps.
    task automatic random_phase(int n_items);
        int    burst;
        int    sent;
        int    r;
        logic  skew;
        sent = 0;
        skew = $urandom_range(0, 1);
        while (sent < n_items) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                r = $urandom_range(0, 99);
                if (r < 82)
                    send_item(abae_pkg::OP_ENCODE,
                              ($urandom_range(0, 9) < 8) ? skew : ~skew,
                              ($urandom_range(0, 1)) ? 6'($urandom_range(0, 3))
                                                     : 6'($urandom_range(0, 63)));
                else if (r < 92)
                    send_item(abae_pkg::OP_FINISH, 1'($urandom), 6'($urandom));
                else if (r < 97)
                    send_item(abae_pkg::OP_RESET, 1'($urandom), 6'($urandom));
                else
                    send_item(abae_pkg::OP_UNUSED, 1'($urandom), 6'($urandom));
                sent++;
            end
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 30));
        end
    endtask

    initial begin
        sb = new();
        sb.power_on();
        stall_mode = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every opcode, field extremes, long runs for E3 and
        // pending-follow flush, end marker from reset and unused opcodes.
        send_item(abae_pkg::OP_ENCODE, 1'b0, 6'd0);
        send_item(abae_pkg::OP_ENCODE, 1'b1, 6'd63);
        send_item(abae_pkg::OP_ENCODE, 1'b1, 6'd63);
        send_item(abae_pkg::OP_ENCODE, 1'b0, 6'd42);
        send_item(abae_pkg::OP_ENCODE, 1'b1, 6'd21);
        send_item(abae_pkg::OP_FINISH, 1'b1, 6'd63);
        send_item(abae_pkg::OP_FINISH, 1'b0, 6'd0);
        send_item(abae_pkg::OP_RESET, 1'b1, 6'd63);
        send_item(abae_pkg::OP_UNUSED, 1'b1, 6'd63);
        repeat (8) send_item(abae_pkg::OP_ENCODE, 1'b0, 6'd5);
        send_item(abae_pkg::OP_ENCODE, 1'b1, 6'd5);
        send_item(abae_pkg::OP_FINISH, 1'b0, 6'd0);
        wait_drained();   // sender holds off until all results are back

        // Extremes of the registers.
        apb_write(ADDR_INIT_TOTAL, 16'd2);
        apb_write(ADDR_RESCALE_TOTAL, 16'd2);
        send_item(abae_pkg::OP_RESET, 1'b0, 6'd0);
        repeat (4) send_item(abae_pkg::OP_ENCODE, 1'b1, 6'd1);
        send_item(abae_pkg::OP_FINISH, 1'b0, 6'd0);
        wait_drained();

        apb_write(ADDR_INIT_TOTAL, 16'hFFFF);
        apb_write(ADDR_RESCALE_TOTAL, 16'hFFFF);
        send_item(abae_pkg::OP_RESET, 1'b0, 6'd0);
        stall_mode = 1;
        random_phase(N_RANDOM / 4);
        send_item(abae_pkg::OP_FINISH, 1'b0, 6'd0);
        wait_drained();

        stall_mode = 2;
        apb_write(ADDR_INIT_TOTAL, 16'($urandom_range(2, 65535)));
        apb_write(ADDR_RESCALE_TOTAL, 16'($urandom_range(2, 300)));
        send_item(abae_pkg::OP_RESET, 1'b0, 6'd0);
        random_phase(N_RANDOM / 4);
        wait_drained();

        stall_mode = 3;
        apb_write(ADDR_INIT_TOTAL, 16'd64);
        apb_write(ADDR_RESCALE_TOTAL, 16'd32);
        random_phase(N_RANDOM / 2);
        wait_drained();

        if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #200ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
